/* hw/rtl/matrix_multiply_4x4_rows_macros.svh */
// Assertion macros, clocked on aclk; the checker supplies aclk and aresetn.
`ifndef MATRIX_MULTIPLY_4X4_ROWS_MACROS_SVH
`define MATRIX_MULTIPLY_4X4_ROWS_MACROS_SVH

// Checked only out of reset.
`define MM4R_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("%m: check failed");

// Checked at every edge, reset included.
`define MM4R_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("%m: check failed");

`endif

/* hw/rtl/mm4r_pkg.sv */
`default_nettype none
package mm4r_pkg;

    localparam int DIM       = 4;
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int ROW_W     = $clog2(DIM);
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = 2 * DATA_W + $clog2(DIM);
    localparam int TDATA_W   = ((ROW_W + DIM * DATA_W + 7) / 8) * 8;

    localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic [DIM-1:0][DATA_W-1:0] row_t;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_MUL  = 1'b1
    } req_t;

    typedef struct packed {
        logic load1;
        logic load2;
    } lane_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/mm4r_lane.sv */
`default_nettype none
// One result column: registered products, registered exact sum, then shift and clip.
module mm4r_lane (
    input  wire logic                      aclk,
    input  wire mm4r_pkg::lane_ctrl_t      ctrl,
    input  wire mm4r_pkg::row_t            left,
    input  wire mm4r_pkg::row_t            col,
    output logic [mm4r_pkg::DATA_W-1:0]    res,
    output logic                           clip
);

    logic signed [mm4r_pkg::PROD_W-1:0] prod_next [mm4r_pkg::DIM];
    logic signed [mm4r_pkg::PROD_W-1:0] prod_reg  [mm4r_pkg::DIM];
    logic signed [mm4r_pkg::SUM_W-1:0]  sum_next;
    logic signed [mm4r_pkg::SUM_W-1:0]  sum_reg;
    logic signed [mm4r_pkg::SUM_W-1:0]  shifted;
    logic [mm4r_pkg::SUM_W-mm4r_pkg::DATA_W:0] upper;
    logic in_range;

    always_comb begin
        for (int k = 0; k < mm4r_pkg::DIM; k++) begin
            prod_next[k] = $signed(left[k]) * $signed(col[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load1) begin
            prod_reg <= prod_next;
        end
    end

    always_comb begin
        sum_next = '0;
        for (int k = 0; k < mm4r_pkg::DIM; k++) begin
            sum_next = sum_next + mm4r_pkg::SUM_W'(prod_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load2) begin
            sum_reg <= sum_next;
        end
    end

    // floor shift, then clip to the signed element range
    always_comb begin
        shifted  = sum_reg >>> mm4r_pkg::FRAC_BITS;
        upper    = shifted[mm4r_pkg::SUM_W-1:mm4r_pkg::DATA_W-1];
        in_range = (&upper) | (~|upper);
        clip     = ~in_range;
        if (in_range) begin
            res = shifted[mm4r_pkg::DATA_W-1:0];
        end else if (shifted[mm4r_pkg::SUM_W-1]) begin
            res = mm4r_pkg::DATA_MIN;
        end else begin
            res = mm4r_pkg::DATA_MAX;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/mm4r_merge.sv */
`default_nettype none
// Gathers the lane results into the output register and folds the clip flags.
module mm4r_merge (
    input  wire logic                         aclk,
    input  wire logic                         load_out,
    input  wire logic [mm4r_pkg::ROW_W-1:0]   row,
    input  wire mm4r_pkg::row_t               res,
    input  wire logic [mm4r_pkg::DIM-1:0]     clip,
    output logic [mm4r_pkg::TDATA_W-1:0]      m_tdata,
    output logic [0:0]                        m_tuser
);

    logic [mm4r_pkg::TDATA_W-1:0] data_next;
    logic [mm4r_pkg::TDATA_W-1:0] data_reg;
    logic                         sat_reg;

    always_comb begin
        data_next = '0;
        data_next[mm4r_pkg::ROW_W-1:0] = row;
        for (int j = 0; j < mm4r_pkg::DIM; j++) begin
            data_next[mm4r_pkg::ROW_W + j*mm4r_pkg::DATA_W +: mm4r_pkg::DATA_W] = res[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            data_reg <= data_next;
            sat_reg  <= |clip;
        end
    end

    assign m_tdata = data_reg;
    assign m_tuser = sat_reg;

endmodule
`default_nettype wire

/* hw/rtl/matrix_multiply_4x4_rows.sv */
`default_nettype none
// Row-streamed 4x4 matrix multiply, signed Q16.16. A load transfer (tuser 0)
// writes one row of the stored right-hand matrix, zero after reset, and is
// seen by the very next transfer; it gives no result. A multiply transfer
// (tuser 1) carries one left-hand row and returns the matching product row,
// each element the exact sum of four 64-bit products, floored by 16 bits and
// clipped to 32 bits; m_tuser flags a row with any clipped element. One
// transfer is taken every cycle unless the input is stalled; a multiply's
// result passes through the multiplier register, the sum register and the
// output register of four column lanes working in parallel. Stages
// advance independently, so input is stalled only when all are full.
module matrix_multiply_4x4_rows (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // row_index[1:0], elem_0[33:2], elem_1[65:34], elem_2[97:66], elem_3[129:98], zero pad
    input  wire logic [mm4r_pkg::TDATA_W-1:0]  s_tdata,
    // req_type[0]
    input  wire logic [0:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // out_row[1:0], out_0[33:2], out_1[65:34], out_2[97:66], out_3[129:98], zero pad
    output logic [mm4r_pkg::TDATA_W-1:0]       m_tdata,
    // saturated[0]
    output logic [0:0]                         m_tuser
);

    mm4r_pkg::row_t right_reg [mm4r_pkg::DIM];
    mm4r_pkg::row_t left;
    mm4r_pkg::row_t col [mm4r_pkg::DIM];
    mm4r_pkg::row_t res;
    logic [mm4r_pkg::DIM-1:0]   clip;
    logic [mm4r_pkg::ROW_W-1:0] row_in;
    logic [mm4r_pkg::ROW_W-1:0] row1_reg, row2_reg;
    logic v1_reg, v2_reg, vout_reg;
    logic v1_next, v2_next, vout_next;
    logic rdy1, rdy2, rdy3;
    logic load_out, s_xfer, is_mul;
    mm4r_pkg::lane_ctrl_t ctrl;

    assign row_in = s_tdata[mm4r_pkg::ROW_W-1:0];
    assign is_mul = (s_tuser == mm4r_pkg::REQ_MUL);

    always_comb begin
        for (int k = 0; k < mm4r_pkg::DIM; k++) begin
            left[k] = s_tdata[mm4r_pkg::ROW_W + k*mm4r_pkg::DATA_W +: mm4r_pkg::DATA_W];
        end
        for (int j = 0; j < mm4r_pkg::DIM; j++) begin
            for (int k = 0; k < mm4r_pkg::DIM; k++) begin
                col[j][k] = right_reg[k][j];
            end
        end
    end

    // stage handshake
    always_comb begin
        rdy3       = ~vout_reg | m_tready;
        rdy2       = ~v2_reg | rdy3;
        rdy1       = ~v1_reg | rdy2;
        s_tready   = rdy1;
        s_xfer     = s_tvalid & rdy1;
        ctrl.load1 = s_xfer & is_mul;
        ctrl.load2 = v1_reg & rdy2;
        load_out   = v2_reg & rdy3;
        v1_next    = ctrl.load1 | (v1_reg & ~rdy2);
        v2_next    = ctrl.load2 | (v2_reg & ~rdy3);
        vout_next  = load_out | (vout_reg & ~m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vout_reg <= 1'b0;
            for (int r = 0; r < mm4r_pkg::DIM; r++) begin
                right_reg[r] <= '0;
            end
        end else begin
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            vout_reg <= vout_next;
            if (s_xfer && !is_mul) begin
                right_reg[row_in] <= left;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load1) begin
            row1_reg <= row_in;
        end
        if (ctrl.load2) begin
            row2_reg <= row1_reg;
        end
    end

    for (genvar j = 0; j < mm4r_pkg::DIM; j++) begin : g_lane
        mm4r_lane u_lane (
            .aclk (aclk),
            .ctrl (ctrl),
            .left (left),
            .col  (col[j]),
            .res  (res[j]),
            .clip (clip[j])
        );
    end

    mm4r_merge u_merge (
        .aclk     (aclk),
        .load_out (load_out),
        .row      (row2_reg),
        .res      (res),
        .clip     (clip),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    assign m_tvalid = vout_reg;

endmodule
`default_nettype wire

/* hw/rtl/mm4r_checker.sv */
`default_nettype none
`include "matrix_multiply_4x4_rows_macros.svh"
module mm4r_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [mm4r_pkg::TDATA_W-1:0]  s_tdata,
    input wire logic [0:0]                    s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mm4r_pkg::TDATA_W-1:0]  m_tdata,
    input wire logic [0:0]                    m_tuser
);

    `MM4R_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `MM4R_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid)
    // output free or draining: the whole pipe can move, so input is open
    `MM4R_ASSERT_ALWAYS(a_in_open, !m_tvalid || m_tready |-> s_tready)
    `MM4R_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[mm4r_pkg::TDATA_W-1:mm4r_pkg::ROW_W+mm4r_pkg::DIM*mm4r_pkg::DATA_W] == '0)

endmodule

bind matrix_multiply_4x4_rows mm4r_checker u_mm4r_checker (.*);
`default_nettype wire
